// ----- rtl/sdes_pkg.sv -----
// Package with the S-DES permutation tables, S-boxes, key types and cipher functions.
`timescale 1ns / 1ps
`default_nettype none

package sdes_pkg;

   // Register indexes of the configuration port.
   localparam logic CSR_KEY = 1'b0;
   localparam logic CSR_IV  = 1'b1;

   // Tables give source bit positions, position 1 being the most significant bit.
   localparam logic [3:0] P10_TAB [10] = '{4'd3, 4'd5, 4'd2, 4'd7, 4'd4,
                                           4'd10, 4'd1, 4'd9, 4'd8, 4'd6};
   localparam logic [3:0] P8_TAB [8]   = '{4'd6, 4'd3, 4'd7, 4'd4, 4'd8, 4'd5, 4'd10, 4'd9};
   localparam logic [3:0] IP_TAB [8]   = '{4'd2, 4'd6, 4'd3, 4'd1, 4'd4, 4'd8, 4'd5, 4'd7};
   localparam logic [3:0] IPINV_TAB [8] = '{4'd4, 4'd1, 4'd3, 4'd5, 4'd7, 4'd2, 4'd8, 4'd6};
   localparam logic [3:0] EP_TAB [8]   = '{4'd4, 4'd1, 4'd2, 4'd3, 4'd2, 4'd3, 4'd4, 4'd1};
   localparam logic [3:0] P4_TAB [4]   = '{4'd2, 4'd4, 4'd3, 4'd1};

   // S-boxes flattened as {row, column}.
   localparam logic [1:0] S0_TAB [16] = '{2'd1, 2'd0, 2'd3, 2'd2,
                                          2'd3, 2'd2, 2'd1, 2'd0,
                                          2'd0, 2'd2, 2'd1, 2'd3,
                                          2'd3, 2'd1, 2'd3, 2'd2};
   localparam logic [1:0] S1_TAB [16] = '{2'd0, 2'd1, 2'd2, 2'd3,
                                          2'd2, 2'd0, 2'd1, 2'd3,
                                          2'd3, 2'd0, 2'd1, 2'd0,
                                          2'd2, 2'd1, 2'd0, 2'd3};

   typedef struct packed {
      logic [7:0] k1;
      logic [7:0] k2;
      logic [7:0] iv;
   } sdes_keys_type;

   function automatic logic [9:0] perm_p10(input logic [9:0] v);
      logic [9:0] o;
      for (int i = 0; i < 10; i++) begin
         o[9 - i] = v[10 - int'(P10_TAB[i])];
      end
      return o;
   endfunction

   function automatic logic [7:0] perm_p8(input logic [9:0] v);
      logic [7:0] o;
      for (int i = 0; i < 8; i++) begin
         o[7 - i] = v[10 - int'(P8_TAB[i])];
      end
      return o;
   endfunction

   function automatic logic [7:0] perm_ip(input logic [7:0] v);
      logic [7:0] o;
      for (int i = 0; i < 8; i++) begin
         o[7 - i] = v[8 - int'(IP_TAB[i])];
      end
      return o;
   endfunction

   function automatic logic [7:0] perm_ipinv(input logic [7:0] v);
      logic [7:0] o;
      for (int i = 0; i < 8; i++) begin
         o[7 - i] = v[8 - int'(IPINV_TAB[i])];
      end
      return o;
   endfunction

   function automatic logic [7:0] perm_ep(input logic [3:0] v);
      logic [7:0] o;
      for (int i = 0; i < 8; i++) begin
         o[7 - i] = v[4 - int'(EP_TAB[i])];
      end
      return o;
   endfunction

   function automatic logic [3:0] perm_p4(input logic [3:0] v);
      logic [3:0] o;
      for (int i = 0; i < 4; i++) begin
         o[3 - i] = v[4 - int'(P4_TAB[i])];
      end
      return o;
   endfunction

   function automatic logic [3:0] round_f(input logic [3:0] r, input logic [7:0] k);
      logic [7:0] e;
      logic [1:0] s0;
      logic [1:0] s1;
      e  = perm_ep(r) ^ k;
      s0 = S0_TAB[{e[7], e[4], e[6:5]}];
      s1 = S1_TAB[{e[3], e[0], e[2:1]}];
      return perm_p4({s0, s1});
   endfunction

   function automatic logic [7:0] sdes_encrypt(input logic [7:0] blk, input logic [7:0] k1,
                                               input logic [7:0] k2);
      logic [7:0] x;
      logic [3:0] l1;
      logic [3:0] l2;
      x  = perm_ip(blk);
      l1 = x[7:4] ^ round_f(x[3:0], k1);
      l2 = x[3:0] ^ round_f(l1, k2);
      return perm_ipinv({l2, l1});
   endfunction

endpackage

`default_nettype wire

// ----- rtl/sdes_ofb_stream_cipher_core.sv -----
// Top level of the S-DES output-feedback stream cipher.
//
// Each item on the req_ channel is one byte in tdata and a start flag in tuser.
// With the start flag set, the feedback block is first reloaded from the
// initialisation vector. The feedback block is then encrypted with S-DES, the
// result becomes the new feedback block, and the byte XOR that block leaves
// on the rsp_ channel. Encryption and decryption are the same operation.
// An accepted item is held in the input register and its result in the result
// register, from which it leaves on rsp_.
// One item is taken every cycle while results are taken on rsp_; the feedback
// register closes through the input-side mux and the two rounds with no
// register between. The csr_ channel writes the key (index 0) or the vector
// (index 1) and is always ready; the subkeys are derived when the key is
// written. Reset clears the keys, the feedback block and all valid flags.
// When rsp_tready is low the result register holds, one more item waits in
// the input register, and req_tready then falls until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module sdes_ofb_stream_cipher_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] data_in
   input  wire logic       req_tuser,   // [0] start_msg
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] data_out
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_index,
   input  wire logic [9:0] csr_data
);

   sdes_pkg::sdes_keys_type keys;

   logic       in_valid_ff;
   logic [7:0] in_data_ff;
   logic       in_start_ff;
   logic       out_valid_ff;
   logic [7:0] out_data_ff;
   logic [7:0] fb_ff;
   logic [7:0] fb_in;
   logic [7:0] cur_block;
   logic       advance;

   sdes_key_sched u_key_sched (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .keys      (keys)
   );

   assign cur_block = in_start_ff ? keys.iv : fb_ff;

   sdes_block_encrypt u_block_encrypt (
      .block_in  (cur_block),
      .keys      (keys),
      .block_out (fb_in)
   );

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         fb_ff        <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            fb_ff        <= fb_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_data_ff  <= req_tdata;
         in_start_ff <= req_tuser;
      end
      if (advance) begin
         out_data_ff <= in_data_ff ^ fb_in;
      end
   end

   a_stall_only_on_full_output: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !req_tready) |-> (out_valid_ff && !rsp_tready))
      else $error("Input stage stalled while the result register could move.");

   a_feedback_moves_with_item: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(fb_ff))
      else $error("Feedback block changed without an item.");

   a_accepted_item_held: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> in_valid_ff)
      else $error("Accepted item was not captured in the input register.");

endmodule

`default_nettype wire

// ----- rtl/sdes_key_sched.sv -----
// Configuration registers with the subkey schedule worked out when the key is written.
`timescale 1ns / 1ps
`default_nettype none

module sdes_key_sched (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   input  wire logic                   csr_index,
   input  wire logic [9:0]             csr_data,
   output sdes_pkg::sdes_keys_type     keys
);

   logic [7:0] k1_ff;
   logic [7:0] k2_ff;
   logic [7:0] iv_ff;
   logic [9:0] p10_key;
   logic [4:0] hi1;
   logic [4:0] lo1;
   logic [4:0] hi2;
   logic [4:0] lo2;

   always_comb begin
      p10_key = sdes_pkg::perm_p10(csr_data);
      hi1     = {p10_key[8:5], p10_key[9]};
      lo1     = {p10_key[3:0], p10_key[4]};
      hi2     = {hi1[2:0], hi1[4:3]};
      lo2     = {lo1[2:0], lo1[4:3]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k1_ff <= '0;
         k2_ff <= '0;
         iv_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            sdes_pkg::CSR_KEY: begin
               k1_ff <= sdes_pkg::perm_p8({hi1, lo1});
               k2_ff <= sdes_pkg::perm_p8({hi2, lo2});
            end
            sdes_pkg::CSR_IV: begin
               iv_ff <= csr_data[7:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign keys.k1 = k1_ff;
   assign keys.k2 = k2_ff;
   assign keys.iv = iv_ff;

endmodule

`default_nettype wire

// ----- rtl/sdes_block_encrypt.sv -----
// Two-round S-DES encryption of one 8-bit block under the two subkeys.
`timescale 1ns / 1ps
`default_nettype none

module sdes_block_encrypt (
   input  wire logic [7:0]             block_in,
   input  sdes_pkg::sdes_keys_type     keys,
   output logic [7:0]                  block_out
);

   assign block_out = sdes_pkg::sdes_encrypt(block_in, keys.k1, keys.k2);

endmodule

`default_nettype wire
